// ===== src/i2csbc_pkg.sv =====
// Shared types and status code constants for the I2C slave buffer controller.
package i2csbc_pkg;

  // Request kinds carried in req_type.
  typedef enum logic [1:0] {
    REQ_BUS   = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_WRITE = 2'd2
  } req_kind_t;

  // Bus control answer carried in ack_action.
  typedef enum logic [1:0] {
    ACK_RELEASE = 2'd0,
    ACK_ACK     = 2'd1,
    ACK_RECOVER = 2'd2
  } ack_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FREAD,
    S_FEMIT
  } ctrl_state_t;

  // The low three bits of a two-wire status code carry no information.
  localparam logic [7:0] CODE_MASK     = 8'hF8;

  localparam logic [7:0] ST_ADDR_W     = 8'h60;
  localparam logic [7:0] ST_ADDR_W_ARB = 8'h68;
  localparam logic [7:0] ST_GCALL      = 8'h70;
  localparam logic [7:0] ST_GCALL_ARB  = 8'h78;
  localparam logic [7:0] ST_DATA_ACK   = 8'h80;
  localparam logic [7:0] ST_DATA_NACK  = 8'h88;
  localparam logic [7:0] ST_GDATA_ACK  = 8'h90;
  localparam logic [7:0] ST_GDATA_NACK = 8'h98;
  localparam logic [7:0] ST_STOP       = 8'hA0;
  localparam logic [7:0] ST_ADDR_R     = 8'hA8;
  localparam logic [7:0] ST_ADDR_R_ARB = 8'hB0;
  localparam logic [7:0] ST_TX_ACK     = 8'hB8;
  localparam logic [7:0] ST_TX_NACK    = 8'hC0;
  localparam logic [7:0] ST_TX_LAST    = 8'hC8;
  localparam logic [7:0] ST_NO_INFO    = 8'hF8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch_start;
    logic fetch_read;
    logic fetch_emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic has_msg;
    logic fetch_last;
  } sts_t;

endpackage

// ===== src/i2csbc_if.sv =====
// Request and result channel interfaces of the I2C slave buffer controller.
interface i2csbc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] status_code;
  logic [7:0] bus_data;
  logic [4:0] host_index;
  logic [7:0] host_byte;

  modport source (
    output valid, req_type, status_code, bus_data, host_index, host_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, status_code, bus_data, host_index, host_byte,
    output ready
  );
endinterface

interface i2csbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] ack_action;
  logic [7:0] tx_data;
  logic       tx_valid;
  logic       msg_valid;
  logic [7:0] msg_byte;
  logic       last;
  logic       refused;

  modport source (
    output valid, ack_action, tx_data, tx_valid, msg_valid, msg_byte, last, refused,
    input  ready
  );
  modport sink (
    input  valid, ack_action, tx_data, tx_valid, msg_valid, msg_byte, last, refused,
    output ready
  );
endinterface

// ===== src/i2csbc_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module i2csbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2csbc_pkg::sts_t  sts,
  output i2csbc_pkg::cmd_t  cmd
);

  i2csbc_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2csbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      i2csbc_pkg::S_IDLE: begin
        if (in_valid) state_next = i2csbc_pkg::S_EXEC;
      end
      i2csbc_pkg::S_EXEC: begin
        if (sts.has_msg) begin
          state_next = i2csbc_pkg::S_FREAD;
        end else if (sts.slot_free) begin
          state_next = i2csbc_pkg::S_IDLE;
        end
      end
      i2csbc_pkg::S_FREAD: begin
        state_next = i2csbc_pkg::S_FEMIT;
      end
      i2csbc_pkg::S_FEMIT: begin
        if (sts.slot_free) begin
          state_next = sts.fetch_last ? i2csbc_pkg::S_IDLE : i2csbc_pkg::S_FREAD;
        end
      end
      default: state_next = i2csbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      i2csbc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      i2csbc_pkg::S_EXEC: begin
        // A fetch that finds a message does not need the output slot yet.
        if (sts.has_msg) begin
          cmd.fetch_start = 1'b1;
        end else if (sts.slot_free) begin
          cmd.exec = 1'b1;
        end
      end
      i2csbc_pkg::S_FREAD: begin
        cmd.fetch_read = 1'b1;
      end
      i2csbc_pkg::S_FEMIT: begin
        cmd.fetch_emit = sts.slot_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == i2csbc_pkg::S_EXEC)
    else $error("captured request did not move to execution");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.fetch_emit) |-> sts.slot_free)
    else $error("result loaded while the output register was occupied");

  a_fetch_end_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch_emit && sts.fetch_last) |=> state == i2csbc_pkg::S_IDLE)
    else $error("fetch did not end after its final byte");

endmodule

// ===== src/i2csbc_dp.sv =====
// Datapath: slave state, receive and transmit buffers, and the result register.
module i2csbc_dp #(
  parameter int BUF_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  i2csbc_pkg::cmd_t cmd,
  output i2csbc_pkg::sts_t sts,
  input  logic [1:0]       in_req_type,
  input  logic [7:0]       in_status_code,
  input  logic [7:0]       in_bus_data,
  input  logic [4:0]       in_host_index,
  input  logic [7:0]       in_host_byte,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_ack_action,
  output logic [7:0]       out_tx_data,
  output logic             out_tx_valid,
  output logic             out_msg_valid,
  output logic [7:0]       out_msg_byte,
  output logic             out_last,
  output logic             out_refused
);

  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int IW = (CW > 5) ? CW : 5;

  // Captured request.
  logic [1:0] r_type;
  logic [7:0] r_code;
  logic [7:0] r_data;
  logic [4:0] r_index;
  logic [7:0] r_byte;

  i2csbc_pkg::mode_t mode, mode_next;
  logic [CW-1:0] rx_count, rx_count_next;
  logic [CW-1:0] tx_pos, tx_pos_next;
  logic [AW-1:0] fetch_k;

  logic [7:0] rx_mem [BUF_BYTES];
  logic [7:0] tx_mem [BUF_BYTES];
  logic [BUF_BYTES-1:0] tx_vld;
  logic [7:0] rx_rd_data;
  logic [7:0] tx_rd_data;
  logic       tx_rd_ok;

  logic [7:0]    cap_code;
  logic [CW-1:0] rd_pos;
  logic [CW-1:0] pos_eff;
  logic          rx_we, tx_we, load;

  logic [1:0] res_ack;
  logic [7:0] res_tx_data;
  logic       res_tx_valid;
  logic       res_msg_valid;
  logic [7:0] res_msg_byte;
  logic       res_last;
  logic       res_refused;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_type  <= in_req_type;
      r_code  <= in_status_code & i2csbc_pkg::CODE_MASK;
      r_data  <= in_bus_data;
      r_index <= in_host_index;
      r_byte  <= in_host_byte;
    end
  end

  // The transmit byte is read while the request is captured; a read address
  // match starts over at position zero.
  assign cap_code = in_status_code & i2csbc_pkg::CODE_MASK;
  assign rd_pos   = (cap_code == i2csbc_pkg::ST_ADDR_R || cap_code == i2csbc_pkg::ST_ADDR_R_ARB)
                    ? '0 : tx_pos;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tx_rd_data <= tx_mem[rd_pos[AW-1:0]];
      tx_rd_ok   <= (rd_pos < CW'(BUF_BYTES)) && tx_vld[rd_pos[AW-1:0]];
    end
    if (tx_we) tx_mem[AW'(r_index)] <= r_byte;
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_count[AW-1:0]] <= r_data;
    if (cmd.fetch_read) rx_rd_data <= rx_mem[fetch_k];
  end

  assign pos_eff = (r_code == i2csbc_pkg::ST_TX_ACK) ? tx_pos : '0;

  always_comb begin
    mode_next     = mode;
    rx_count_next = rx_count;
    tx_pos_next   = tx_pos;
    rx_we         = 1'b0;
    tx_we         = 1'b0;
    res_ack       = i2csbc_pkg::ACK_RELEASE;
    res_tx_data   = '0;
    res_tx_valid  = 1'b0;
    res_msg_valid = 1'b0;
    res_msg_byte  = '0;
    res_last      = 1'b1;
    res_refused   = 1'b0;

    if (cmd.exec) begin
      unique case (r_type)
        i2csbc_pkg::REQ_BUS: begin
          unique case (r_code) inside
            i2csbc_pkg::ST_ADDR_W, i2csbc_pkg::ST_ADDR_W_ARB,
            i2csbc_pkg::ST_GCALL, i2csbc_pkg::ST_GCALL_ARB: begin
              mode_next     = i2csbc_pkg::MODE_RX;
              rx_count_next = '0;
              res_ack       = i2csbc_pkg::ACK_ACK;
            end
            i2csbc_pkg::ST_DATA_ACK, i2csbc_pkg::ST_GDATA_ACK,
            i2csbc_pkg::ST_DATA_NACK, i2csbc_pkg::ST_GDATA_NACK: begin
              // A full buffer drops the byte and answers not-acknowledge.
              if (rx_count < CW'(BUF_BYTES)) begin
                rx_we         = 1'b1;
                rx_count_next = rx_count + CW'(1);
                if (r_code == i2csbc_pkg::ST_DATA_ACK || r_code == i2csbc_pkg::ST_GDATA_ACK) begin
                  res_ack = i2csbc_pkg::ACK_ACK;
                end
              end
            end
            i2csbc_pkg::ST_STOP: begin
              mode_next = i2csbc_pkg::MODE_IDLE;
              res_ack   = i2csbc_pkg::ACK_ACK;
            end
            i2csbc_pkg::ST_ADDR_R, i2csbc_pkg::ST_ADDR_R_ARB, i2csbc_pkg::ST_TX_ACK: begin
              if (r_code != i2csbc_pkg::ST_TX_ACK) mode_next = i2csbc_pkg::MODE_TX;
              res_tx_data  = tx_rd_ok ? tx_rd_data : '0;
              res_tx_valid = 1'b1;
              tx_pos_next  = (pos_eff < CW'(BUF_BYTES)) ? pos_eff + CW'(1) : pos_eff;
              res_ack      = i2csbc_pkg::ACK_ACK;
            end
            i2csbc_pkg::ST_TX_NACK, i2csbc_pkg::ST_TX_LAST: begin
              tx_pos_next = '0;
              mode_next   = i2csbc_pkg::MODE_IDLE;
              res_ack     = i2csbc_pkg::ACK_ACK;
            end
            i2csbc_pkg::ST_NO_INFO: begin
              res_ack = i2csbc_pkg::ACK_RELEASE;
            end
            default: begin
              rx_count_next = '0;
              tx_pos_next   = '0;
              mode_next     = i2csbc_pkg::MODE_IDLE;
              res_ack       = i2csbc_pkg::ACK_RECOVER;
            end
          endcase
        end
        i2csbc_pkg::REQ_FETCH: begin
          // Only a fetch that finds nothing reaches here.
          res_msg_valid = 1'b0;
        end
        i2csbc_pkg::REQ_WRITE: begin
          if (mode == i2csbc_pkg::MODE_TX) begin
            res_refused = 1'b1;
          end else begin
            if (IW'(r_index) < IW'(BUF_BYTES)) tx_we = 1'b1;
            if (r_index == '0) tx_pos_next = '0;
          end
        end
        default: begin
          res_last = 1'b1;
        end
      endcase
    end

    if (cmd.fetch_emit) begin
      res_msg_valid = 1'b1;
      res_msg_byte  = rx_rd_data;
      res_last      = sts.fetch_last;
      if (sts.fetch_last) rx_count_next = '0;
    end
  end

  assign load = cmd.exec || cmd.fetch_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= i2csbc_pkg::MODE_IDLE;
      rx_count  <= '0;
      tx_pos    <= '0;
      tx_vld    <= '0;
      fetch_k   <= '0;
      out_valid <= 1'b0;
    end else begin
      mode     <= mode_next;
      rx_count <= rx_count_next;
      tx_pos   <= tx_pos_next;
      if (tx_we) tx_vld[AW'(r_index)] <= 1'b1;
      if (cmd.fetch_start) begin
        fetch_k <= '0;
      end else if (cmd.fetch_emit) begin
        fetch_k <= fetch_k + AW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ack_action <= res_ack;
      out_tx_data    <= res_tx_data;
      out_tx_valid   <= res_tx_valid;
      out_msg_valid  <= res_msg_valid;
      out_msg_byte   <= res_msg_byte;
      out_last       <= res_last;
      out_refused    <= res_refused;
    end
  end

  assign sts.slot_free  = !out_valid || out_ready;
  assign sts.has_msg    = (r_type == i2csbc_pkg::REQ_FETCH) && (mode != i2csbc_pkg::MODE_RX)
                          && (rx_count != '0);
  assign sts.fetch_last = (CW'(fetch_k) + CW'(1)) == rx_count;

  a_fetch_clears_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch_emit && sts.fetch_last) |=> rx_count == '0)
    else $error("receive count not cleared after a fetch");

  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(BUF_BYTES))
    else $error("receive count beyond buffer size");

  a_tx_pos_bound: assert property (@(posedge clk) disable iff (rst)
    tx_pos <= CW'(BUF_BYTES))
    else $error("transmit position beyond buffer size");

endmodule

// ===== src/i2c_slave_buffer_controller.sv =====
// Top level of the I2C slave buffer controller: controller and datapath.
//
//   Channel  Dir  Carries
//   req      in   req_type, status_code, bus_data, host_index, host_byte
//   rsp      out  ack_action, tx_data, tx_valid, msg_valid, msg_byte, last, refused
//
// A bus event, host write or unused request is accepted in S_IDLE, where the
// transmit buffer is read, and loads the result register in S_EXEC.
// A fetch of n received bytes passes S_IDLE and S_EXEC; each byte then needs a
// registered read of the receive buffer followed by a load of the result.
// Reset is synchronous and clears the state, mode, counts, transmit valid bits and out_valid.
// A waiting result does not block the next request; execution holds only
// while the result register is still occupied.
module i2c_slave_buffer_controller #(
  parameter int BUF_BYTES = 32
) (
  input logic          clk,
  input logic          rst,
  i2csbc_req_if.sink   req,
  i2csbc_rsp_if.source rsp
);

  i2csbc_pkg::cmd_t cmd;
  i2csbc_pkg::sts_t sts;
  logic             in_ready;

  assign req.ready = in_ready;

  i2csbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2csbc_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (req.req_type),
    .in_status_code (req.status_code),
    .in_bus_data    (req.bus_data),
    .in_host_index  (req.host_index),
    .in_host_byte   (req.host_byte),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .out_ack_action (rsp.ack_action),
    .out_tx_data    (rsp.tx_data),
    .out_tx_valid   (rsp.tx_valid),
    .out_msg_valid  (rsp.msg_valid),
    .out_msg_byte   (rsp.msg_byte),
    .out_last       (rsp.last),
    .out_refused    (rsp.refused)
  );

endmodule
